[src/cps_pkg.sv]
// ----------------------------------------------------------------------------
// Converter precharge sequencer package
// Shared state encoding, current-loop codes and configuration indexes.
// ----------------------------------------------------------------------------
package cps_pkg;

	// Sequencer states as reported on the result channel.
	typedef enum logic [2:0] {
		ST_FAULT_OFF      = 3'd0,
		ST_FAULT_STOPPING = 3'd1,
		ST_OFF            = 3'd2,
		ST_STOPPING       = 3'd3,
		ST_PRECHARGING    = 3'd4,
		ST_PRECHARGED     = 3'd5,
		ST_ON             = 3'd6
	} state_t;

	// Current-loop state codes.
	typedef enum logic [1:0] {
		LOOP_OTHER    = 2'd0,
		LOOP_OFF      = 2'd1,
		LOOP_STOPPING = 2'd2,
		LOOP_FAULT    = 2'd3
	} loop_state_t;

	// Configuration register indexes.
	localparam int CFG_INDEX_WIDTH = 1;
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_DISCHARGED_THRESHOLD = 1'd0,
		CFG_PRECHARGED_MINIMUM   = 1'd1
	} cfg_index_t;

	// Register reset values.
	localparam int DISCHARGED_THRESHOLD_RESET = 100;
	localparam int PRECHARGED_MINIMUM_RESET   = 1000;

	// Narrowest signed width that holds both reset values.
	localparam int THRESHOLD_MIN_WIDTH = 11;

endpackage

[src/converter_precharge_sequencer.sv]
// ----------------------------------------------------------------------------
// Converter precharge sequencer
// Seven-state precharge and fault sequencer for a converter front end.
// ----------------------------------------------------------------------------
// Each input transaction is one control tick carrying the DC bus voltage,
// breaker and contactor feedback, the current-loop state, fault flags and
// the run and unblock commands. The block returns one result transaction per
// tick with the sequencer state after that tick. The tick is captured in an
// input register, the guards of the current state are evaluated in their
// fixed priority (fault first) by a single level of logic, and the new state
// is written both to the state register and to the result register. A new
// tick is accepted in every cycle in which in_stall is low; the result is
// offered once the tick leaves the input register. in_stall is raised only
// while both registers are full and the result is stalled. The two voltage
// thresholds go in through the configuration port; the user must write them
// only while idle, not enforced by the block; unused indexes are ignored.
module converter_precharge_sequencer #(
	parameter int VOLTAGE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_we,
	input  logic [cps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [VOLTAGE_WIDTH-1:0]          cfg_data,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [VOLTAGE_WIDTH-1:0]   bus_voltage,
	input  logic                              breaker_open,
	input  logic                              contactor1_open,
	input  logic                              contactor2_open,
	input  logic                              contactor3_open,
	input  logic [1:0]                        current_loop_state,
	input  logic                              modulator_fault_off,
	input  logic                              gateware_fault,
	input  logic                              interlock_active,
	input  logic                              run_request,
	input  logic                              unblock_request,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        sequencer_state
);
	import cps_pkg::*;

	// Thresholds are kept wide enough for their reset values even when the
	// voltage path is narrow; the bus sample is sign extended to match.
	localparam int THR_WIDTH = (VOLTAGE_WIDTH > THRESHOLD_MIN_WIDTH) ?
		VOLTAGE_WIDTH : THRESHOLD_MIN_WIDTH;

	logic signed [THR_WIDTH-1:0] discharged_threshold_q;
	logic signed [THR_WIDTH-1:0] precharged_minimum_q;
	logic signed [THR_WIDTH-1:0] cfg_value;

	// Input register stage.
	logic                           valid_s1;
	logic signed [VOLTAGE_WIDTH-1:0] bus_voltage_s1;
	logic                           breaker_open_s1;
	logic                           contactor1_open_s1;
	logic                           contactor2_open_s1;
	logic                           contactor3_open_s1;
	loop_state_t                    loop_s1;
	logic                           modulator_fault_off_s1;
	logic                           gateware_fault_s1;
	logic                           interlock_active_s1;
	logic                           run_request_s1;
	logic                           unblock_request_s1;

	state_t state_q;
	state_t next_state;
	logic   out_valid_q;
	state_t result_q;

	logic                        advance;
	logic                        in_fire;
	logic signed [THR_WIDTH-1:0] vdc;
	logic                        fault;
	logic                        discharged;
	logic                        precharge_done;

	// The input stage moves on whenever the result register can take a value.
	assign advance  = ~out_valid_q | ~out_stall;
	assign in_stall = valid_s1 & ~advance;
	assign in_fire  = in_valid & ~in_stall;

	// Configuration registers. The written value is two's complement.
	assign cfg_value = THR_WIDTH'($signed(cfg_data));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discharged_threshold_q <= THR_WIDTH'(DISCHARGED_THRESHOLD_RESET);
			precharged_minimum_q   <= THR_WIDTH'(PRECHARGED_MINIMUM_RESET);
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_DISCHARGED_THRESHOLD: discharged_threshold_q <= cfg_value;
				CFG_PRECHARGED_MINIMUM:   precharged_minimum_q   <= cfg_value;
				default: ;
			endcase
		end
	end

	// Input register: valid bit under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			bus_voltage_s1         <= bus_voltage;
			breaker_open_s1        <= breaker_open;
			contactor1_open_s1     <= contactor1_open;
			contactor2_open_s1     <= contactor2_open;
			contactor3_open_s1     <= contactor3_open;
			loop_s1                <= loop_state_t'(current_loop_state);
			modulator_fault_off_s1 <= modulator_fault_off;
			gateware_fault_s1      <= gateware_fault;
			interlock_active_s1    <= interlock_active;
			run_request_s1         <= run_request;
			unblock_request_s1     <= unblock_request;
		end
	end

	// Guard terms; the fault term is shared by several states.
	assign vdc   = THR_WIDTH'(bus_voltage_s1);
	assign fault = gateware_fault_s1 | interlock_active_s1 |
		(loop_s1 == LOOP_FAULT) | modulator_fault_off_s1;
	assign discharged = (vdc < discharged_threshold_q) & breaker_open_s1 &
		contactor1_open_s1 & contactor2_open_s1;
	assign precharge_done = ~breaker_open_s1 & contactor1_open_s1 &
		contactor3_open_s1 & (vdc >= precharged_minimum_q);

	// Next state: first guard that holds wins, otherwise the state stays.
	always_comb begin
		next_state = state_q;
		case (state_q)
			ST_FAULT_OFF: begin
				if (loop_s1 == LOOP_OFF) next_state = ST_OFF;
			end
			ST_FAULT_STOPPING: begin
				if (discharged) next_state = ST_FAULT_OFF;
			end
			ST_OFF: begin
				if (fault) next_state = ST_FAULT_STOPPING;
				else if (run_request_s1) next_state = ST_PRECHARGING;
			end
			ST_STOPPING: begin
				if (fault) next_state = ST_FAULT_STOPPING;
				else if (loop_s1 == LOOP_OFF) next_state = ST_OFF;
			end
			ST_PRECHARGING: begin
				if (fault) next_state = ST_FAULT_STOPPING;
				else if (precharge_done) next_state = ST_PRECHARGED;
			end
			ST_PRECHARGED: begin
				if (fault || loop_s1 == LOOP_STOPPING) next_state = ST_FAULT_STOPPING;
				else if (unblock_request_s1) next_state = ST_ON;
			end
			ST_ON: begin
				if (fault) next_state = ST_FAULT_STOPPING;
				else if (loop_s1 == LOOP_STOPPING) next_state = ST_STOPPING;
			end
			default: next_state = state_q;
		endcase
	end

	// State register: one move per tick, taken when the tick leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FAULT_OFF;
		end else if (valid_s1 && advance) begin
			state_q <= next_state;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_q <= next_state;
		end
	end

	assign out_valid       = out_valid_q;
	assign sequencer_state = result_q;

endmodule

[src/cps_checker.sv]
// ----------------------------------------------------------------------------
// Converter precharge sequencer checker
// Port-level assertions on handshake behavior and reported state moves.
// ----------------------------------------------------------------------------
module cps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] sequencer_state
);
	import cps_pkg::*;

	logic   out_fire;
	state_t last_state_q;
	logic   legal_move;

	assign out_fire = out_valid & ~out_stall;

	// Last state delivered, starting from the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_state_q <= ST_FAULT_OFF;
		end else if (out_fire) begin
			last_state_q <= state_t'(sequencer_state);
		end
	end

	// Each delivered state is the previous one or one of its successors.
	always_comb begin
		case (last_state_q)
			ST_FAULT_OFF: legal_move = sequencer_state == ST_FAULT_OFF ||
				sequencer_state == ST_OFF;
			ST_FAULT_STOPPING: legal_move = sequencer_state == ST_FAULT_STOPPING ||
				sequencer_state == ST_FAULT_OFF;
			ST_OFF: legal_move = sequencer_state == ST_OFF ||
				sequencer_state == ST_FAULT_STOPPING || sequencer_state == ST_PRECHARGING;
			ST_STOPPING: legal_move = sequencer_state == ST_STOPPING ||
				sequencer_state == ST_FAULT_STOPPING || sequencer_state == ST_OFF;
			ST_PRECHARGING: legal_move = sequencer_state == ST_PRECHARGING ||
				sequencer_state == ST_FAULT_STOPPING || sequencer_state == ST_PRECHARGED;
			ST_PRECHARGED: legal_move = sequencer_state == ST_PRECHARGED ||
				sequencer_state == ST_FAULT_STOPPING || sequencer_state == ST_ON;
			ST_ON: legal_move = sequencer_state == ST_ON ||
				sequencer_state == ST_FAULT_STOPPING || sequencer_state == ST_STOPPING;
			default: legal_move = 1'b0;
		endcase
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sequencer_state))
		else $error("stalled result transaction changed or was dropped");

	a_no_unused_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sequencer_state != 3'd7)
		else $error("unused state code reported");

	a_legal_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> legal_move)
		else $error("illegal state move between consecutive results");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the result side was free");

endmodule

bind converter_precharge_sequencer cps_checker u_cps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.sequencer_state (sequencer_state)
);
